/* rtl/lav_pkg.sv */
package lav_pkg;

  localparam int Q_W        = 32;
  localparam int FRAC       = 16;
  localparam int RAW_W      = 40;
  localparam int UNIT_W     = 18;
  localparam int NU_W       = 19;
  localparam int P_W        = 36;
  localparam int PE_W       = 50;
  localparam int PU_W       = 51;
  localparam int DOT_W      = 52;
  localparam int LEN_W      = 6;
  localparam int NORM_TOP   = 30;
  localparam int SQ_W       = 63;
  localparam int ROOT_W     = 31;
  localparam int DV_W       = 48;
  localparam int QT_W       = 17;
  localparam int NORM_FRONT = 6;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 17;
  // front end, root steps, dividend set-up, quotient steps, sign
  localparam int NORM_LAT   = NORM_FRONT + SQRT_STEPS + DIV_STEPS + 2;

  localparam int Q_ONE = 65536;
  localparam int HALF  = 32768;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [Q_W-1:0]    q16_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [NU_W-1:0]   nu_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

  typedef struct packed {
    q16_t e0;
    q16_t e1;
    q16_t e2;
    q16_t e3;
  } row_t;

  typedef struct packed {
    row_t r0;
    row_t r1;
    row_t r2;
  } mat_t;

  // round a Q32.32 cross term to Q16.16, half away from zero
  function automatic nu_t round_nu(input logic signed [P_W:0] x);
    logic [P_W:0] m;
    logic [P_W:0] r;
    m = x[P_W] ? (P_W+1)'(-x) : (P_W+1)'(x);
    r = (m + (P_W+1)'(HALF)) >> FRAC;
    return x[P_W] ? -nu_t'(r) : nu_t'(r);
  endfunction

  // minus the rounded dot product, clamped to 32 bits
  function automatic q16_t col3(input dot_t d);
    logic [DOT_W-1:0] m;
    logic [DOT_W-1:0] r;
    q16_t o;
    m = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
    r = (m + DOT_W'(HALF)) >> FRAC;
    if (d[DOT_W-1]) begin
      if (r > DOT_W'(32'h7fff_ffff)) o = 32'sh7fff_ffff;
      else o = q16_t'(r);
    end else begin
      if (r > DOT_W'(32'h8000_0000)) o = 32'sh8000_0000;
      else o = q16_t'(DOT_W'(0) - r);
    end
    return o;
  endfunction

endpackage

/* rtl/lav_norm.sv */
module lav_norm (
  input  logic          clk,
  input  logic          en,
  input  lav_pkg::raw_t v [3],
  output lav_pkg::unit_t u [3]
);

  typedef struct packed {
    logic                                   zero;
    logic [2:0]                             neg;
    logic [2:0][lav_pkg::NORM_TOP-1:0]      a;
  } sb_t;

  logic [2:0][lav_pkg::RAW_W-1:0]      a1, a2, a3;
  logic [2:0]                          neg1, neg2, neg3;
  logic [lav_pkg::RAW_W-1:0]           mx, mx2;
  logic [lav_pkg::LEN_W-1:0]           len, len3;
  sb_t                                 sb4, sb5;
  logic [2:0][2*lav_pkg::NORM_TOP-1:0] sq5;

  logic [lav_pkg::SQ_W-1:0] rem [lav_pkg::SQRT_STEPS+1];
  logic [lav_pkg::SQ_W-1:0] res [lav_pkg::SQRT_STEPS+1];
  sb_t                      sbq [lav_pkg::SQRT_STEPS+1];

  logic [lav_pkg::ROOT_W-1:0]          m_root;
  logic [2:0][lav_pkg::DV_W-1:0]       drem [lav_pkg::DIV_STEPS+1];
  logic [2:0][lav_pkg::QT_W-1:0]       qd   [lav_pkg::DIV_STEPS+1];
  logic [lav_pkg::ROOT_W-1:0]          dsr  [lav_pkg::DIV_STEPS+1];
  sb_t                                 sbd  [lav_pkg::DIV_STEPS+1];

  always_comb begin
    mx = a1[0];
    if (a1[1] > mx) mx = a1[1];
    if (a1[2] > mx) mx = a1[2];
  end

  // bit length of the largest magnitude
  always_comb begin
    len = '0;
    for (int j = 0; j < lav_pkg::RAW_W; j++) begin
      if (mx2[j]) len = lav_pkg::LEN_W'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]   <= v[i][lav_pkg::RAW_W-1] ? lav_pkg::RAW_W'(-v[i]) : lav_pkg::RAW_W'(v[i]);
        neg1[i] <= v[i][lav_pkg::RAW_W-1];
      end
      a2   <= a1;
      neg2 <= neg1;
      mx2  <= mx;
      a3   <= a2;
      neg3 <= neg2;
      len3 <= len;
      for (int i = 0; i < 3; i++) begin
        if (len3 > lav_pkg::LEN_W'(lav_pkg::NORM_TOP))
          sb4.a[i] <= lav_pkg::NORM_TOP'(a3[i] >> (len3 - lav_pkg::LEN_W'(lav_pkg::NORM_TOP)));
        else
          sb4.a[i] <= lav_pkg::NORM_TOP'(a3[i] << (lav_pkg::LEN_W'(lav_pkg::NORM_TOP) - len3));
        sq5[i] <= sb4.a[i] * sb4.a[i];
      end
      sb4.neg  <= neg3;
      sb4.zero <= (len3 == '0);
      sb5      <= sb4;
      rem[0]   <= lav_pkg::SQ_W'(sq5[0]) + lav_pkg::SQ_W'(sq5[1]) + lav_pkg::SQ_W'(sq5[2]);
      res[0]   <= '0;
      sbq[0]   <= sb5;
    end
  end

  // integer square root, one result bit per stage
  for (genvar t = 0; t < lav_pkg::SQRT_STEPS; t++) begin : g_sqrt
    localparam logic [lav_pkg::SQ_W-1:0] BITV =
      lav_pkg::SQ_W'(1) << (2 * (lav_pkg::SQRT_STEPS - 1 - t));
    logic [lav_pkg::SQ_W-1:0] trial;
    assign trial = res[t] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[t] >= trial) begin
          rem[t+1] <= rem[t] - trial;
          res[t+1] <= (res[t] >> 1) + BITV;
        end else begin
          rem[t+1] <= rem[t];
          res[t+1] <= res[t] >> 1;
        end
        sbq[t+1] <= sbq[t];
      end
    end
  end

  assign m_root = res[lav_pkg::SQRT_STEPS][lav_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= lav_pkg::DV_W'({sbq[lav_pkg::SQRT_STEPS].a[i], 16'b0})
                    + lav_pkg::DV_W'(m_root >> 1);
      end
      qd[0]  <= '0;
      dsr[0] <= m_root;
      sbd[0] <= sbq[lav_pkg::SQRT_STEPS];
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar t = 0; t < lav_pkg::DIV_STEPS; t++) begin : g_div
    localparam int SH = lav_pkg::DIV_STEPS - 1 - t;
    logic [lav_pkg::DV_W-1:0]      cmp;
    logic [2:0][lav_pkg::DV_W-1:0] rn;
    logic [2:0][lav_pkg::QT_W-1:0] qn;
    assign cmp = lav_pkg::DV_W'(dsr[t]) << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rn[i] = drem[t][i];
        qn[i] = qd[t][i];
        if (drem[t][i] >= cmp) begin
          rn[i]     = drem[t][i] - cmp;
          qn[i][SH] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem[t+1] <= rn;
        qd[t+1]   <= qn;
        dsr[t+1]  <= dsr[t];
        sbd[t+1]  <= sbd[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (sbd[lav_pkg::DIV_STEPS].zero)
          u[i] <= '0;
        else if (sbd[lav_pkg::DIV_STEPS].neg[i])
          u[i] <= -lav_pkg::unit_t'({1'b0, qd[lav_pkg::DIV_STEPS][i]});
        else
          u[i] <= lav_pkg::unit_t'({1'b0, qd[lav_pkg::DIV_STEPS][i]});
      end
    end
  end

endmodule

/* rtl/lav_rows.sv */
module lav_rows (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lav_pkg::mat_t       mat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          row_index,
  output logic signed [31:0]  entry_0,
  output logic signed [31:0]  entry_1,
  output logic signed [31:0]  entry_2,
  output logic signed [31:0]  entry_3,
  output logic                last_row
);

  logic          busy;
  logic [1:0]    cnt;
  lav_pkg::mat_t held;
  lav_pkg::row_t row;

  assign item_ready = !busy || (out_ready && cnt == lav_pkg::ROW_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= lav_pkg::ROW_SIDE;
    end else if (item_valid && item_ready) begin
      busy <= 1'b1;
      cnt  <= lav_pkg::ROW_SIDE;
    end else if (busy && out_ready) begin
      cnt <= cnt + 2'd1;
      if (cnt == lav_pkg::ROW_LAST) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) held <= mat;
  end

  always_comb begin
    unique case (cnt)
      lav_pkg::ROW_SIDE: row = held.r0;
      lav_pkg::ROW_UP:   row = held.r1;
      lav_pkg::ROW_FWD:  row = held.r2;
      default: begin
        row.e0 = '0;
        row.e1 = '0;
        row.e2 = '0;
        row.e3 = lav_pkg::q16_t'(lav_pkg::Q_ONE);
      end
    endcase
  end

  assign out_valid = busy;
  assign row_index = cnt;
  assign entry_0   = row.e0;
  assign entry_1   = row.e1;
  assign entry_2   = row.e2;
  assign entry_3   = row.e3;
  assign last_row  = (cnt == lav_pkg::ROW_LAST);

  a_hold_row: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |=> busy && $stable(cnt))
    else $error("row advanced without a taken request");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> busy && cnt == lav_pkg::ROW_SIDE)
    else $error("new matrix did not start at row 0");

  a_step_row: assert property (@(posedge clk) disable iff (rst)
    busy && out_ready && cnt != lav_pkg::ROW_LAST |=> busy && cnt == $past(cnt) + 2'd1)
    else $error("row sequence skipped");

endmodule

/* rtl/look_at_view_matrix.sv */
// an item passes the input register, the forward and up normalizers, the side cross product,
// the side normalizer and the up and dot stages; the row serializer then offers its rows,
// one per cycle while out_ready is high, and takes the next item as its last row is taken;
// the two normalize passes in series (square root and divide one bit per stage) set the depth
// stalls freeze all stages ahead of the serializer; reset clears only valid bits and serializer
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row_index,
  output logic signed [31:0] entry_0,
  output logic signed [31:0] entry_1,
  output logic signed [31:0] entry_2,
  output logic signed [31:0] entry_3,
  output logic               last_row
);

  logic en, ser_ready;

  logic                               v0, v1, v2, v3, v4, v5, v6, v7;
  logic [lav_pkg::NORM_LAT-1:0]       va_dl, vb_dl;

  lav_pkg::q16_t  eye0 [3];
  lav_pkg::raw_t  fr0  [3];
  lav_pkg::raw_t  up0  [3];
  lav_pkg::unit_t fwd_a [3];
  lav_pkg::unit_t upn_a [3];
  lav_pkg::q16_t  eye_dla [lav_pkg::NORM_LAT][3];

  logic signed [lav_pkg::P_W-1:0] xp1 [6];
  lav_pkg::unit_t fwd1 [3];
  lav_pkg::q16_t  eye1 [3];
  lav_pkg::raw_t  sraw2 [3];
  lav_pkg::unit_t fwd2 [3];
  lav_pkg::q16_t  eye2 [3];

  lav_pkg::unit_t side_b [3];
  lav_pkg::unit_t fwd_dlb [lav_pkg::NORM_LAT][3];
  lav_pkg::q16_t  eye_dlb [lav_pkg::NORM_LAT][3];

  logic signed [lav_pkg::P_W-1:0]  np3 [6];
  logic signed [lav_pkg::PE_W-1:0] ds3 [3];
  logic signed [lav_pkg::PE_W-1:0] df3 [3];
  lav_pkg::unit_t side3 [3], side4 [3], side5 [3], side6 [3];
  lav_pkg::unit_t fwd3 [3], fwd4 [3], fwd5 [3], fwd6 [3];
  lav_pkg::q16_t  eye3 [3], eye4 [3];
  lav_pkg::nu_t   nu4 [3], nu5 [3], nu6 [3];
  lav_pkg::dot_t  dot_s4, dot_f4, dot_u6;
  logic signed [lav_pkg::PU_W-1:0] du5 [3];
  lav_pkg::q16_t  e3_s5, e3_f5, e3_s6, e3_f6;
  lav_pkg::mat_t  mat7;

  assign en       = !v7 || ser_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
      va_dl <= '0;
      vb_dl <= '0;
    end else if (en) begin
      v0    <= in_valid;
      va_dl <= {va_dl[lav_pkg::NORM_LAT-2:0], v0};
      v1    <= va_dl[lav_pkg::NORM_LAT-1];
      v2    <= v1;
      vb_dl <= {vb_dl[lav_pkg::NORM_LAT-2:0], v2};
      v3    <= vb_dl[lav_pkg::NORM_LAT-1];
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      v7    <= v6;
    end
  end

  // forward is target minus eye, exact in the wider raw format
  always_ff @(posedge clk) begin
    if (en) begin
      eye0[0] <= eye_x;
      eye0[1] <= eye_y;
      eye0[2] <= eye_z;
      fr0[0]  <= lav_pkg::raw_t'(target_x) - lav_pkg::raw_t'(eye_x);
      fr0[1]  <= lav_pkg::raw_t'(target_y) - lav_pkg::raw_t'(eye_y);
      fr0[2]  <= lav_pkg::raw_t'(target_z) - lav_pkg::raw_t'(eye_z);
      up0[0]  <= lav_pkg::raw_t'(upward_x);
      up0[1]  <= lav_pkg::raw_t'(upward_y);
      up0[2]  <= lav_pkg::raw_t'(upward_z);
    end
  end

  lav_norm u_norm_fwd (.clk(clk), .en(en), .v(fr0), .u(fwd_a));
  lav_norm u_norm_up  (.clk(clk), .en(en), .v(up0), .u(upn_a));

  always_ff @(posedge clk) begin
    if (en) begin
      eye_dla[0] <= eye0;
      for (int k = 1; k < lav_pkg::NORM_LAT; k++) eye_dla[k] <= eye_dla[k-1];
    end
  end

  // side = forward x up
  always_ff @(posedge clk) begin
    if (en) begin
      xp1[0] <= fwd_a[1] * upn_a[2];
      xp1[1] <= fwd_a[2] * upn_a[1];
      xp1[2] <= fwd_a[2] * upn_a[0];
      xp1[3] <= fwd_a[0] * upn_a[2];
      xp1[4] <= fwd_a[0] * upn_a[1];
      xp1[5] <= fwd_a[1] * upn_a[0];
      fwd1   <= fwd_a;
      eye1   <= eye_dla[lav_pkg::NORM_LAT-1];
      sraw2[0] <= lav_pkg::raw_t'(xp1[0]) - lav_pkg::raw_t'(xp1[1]);
      sraw2[1] <= lav_pkg::raw_t'(xp1[2]) - lav_pkg::raw_t'(xp1[3]);
      sraw2[2] <= lav_pkg::raw_t'(xp1[4]) - lav_pkg::raw_t'(xp1[5]);
      fwd2   <= fwd1;
      eye2   <= eye1;
    end
  end

  lav_norm u_norm_side (.clk(clk), .en(en), .v(sraw2), .u(side_b));

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_dlb[0] <= fwd2;
      eye_dlb[0] <= eye2;
      for (int k = 1; k < lav_pkg::NORM_LAT; k++) begin
        fwd_dlb[k] <= fwd_dlb[k-1];
        eye_dlb[k] <= eye_dlb[k-1];
      end
    end
  end

  // up = side x forward, then the three dot products with the eye
  always_ff @(posedge clk) begin
    if (en) begin
      np3[0] <= side_b[1] * fwd_dlb[lav_pkg::NORM_LAT-1][2];
      np3[1] <= side_b[2] * fwd_dlb[lav_pkg::NORM_LAT-1][1];
      np3[2] <= side_b[2] * fwd_dlb[lav_pkg::NORM_LAT-1][0];
      np3[3] <= side_b[0] * fwd_dlb[lav_pkg::NORM_LAT-1][2];
      np3[4] <= side_b[0] * fwd_dlb[lav_pkg::NORM_LAT-1][1];
      np3[5] <= side_b[1] * fwd_dlb[lav_pkg::NORM_LAT-1][0];
      for (int i = 0; i < 3; i++) begin
        ds3[i] <= side_b[i] * eye_dlb[lav_pkg::NORM_LAT-1][i];
        df3[i] <= fwd_dlb[lav_pkg::NORM_LAT-1][i] * eye_dlb[lav_pkg::NORM_LAT-1][i];
      end
      side3 <= side_b;
      fwd3  <= fwd_dlb[lav_pkg::NORM_LAT-1];
      eye3  <= eye_dlb[lav_pkg::NORM_LAT-1];

      nu4[0] <= lav_pkg::round_nu((lav_pkg::P_W+1)'(np3[0]) - (lav_pkg::P_W+1)'(np3[1]));
      nu4[1] <= lav_pkg::round_nu((lav_pkg::P_W+1)'(np3[2]) - (lav_pkg::P_W+1)'(np3[3]));
      nu4[2] <= lav_pkg::round_nu((lav_pkg::P_W+1)'(np3[4]) - (lav_pkg::P_W+1)'(np3[5]));
      dot_s4 <= lav_pkg::DOT_W'(ds3[0]) + lav_pkg::DOT_W'(ds3[1]) + lav_pkg::DOT_W'(ds3[2]);
      // third row is minus forward
      dot_f4 <= -(lav_pkg::DOT_W'(df3[0]) + lav_pkg::DOT_W'(df3[1])
                  + lav_pkg::DOT_W'(df3[2]));
      side4 <= side3;
      fwd4  <= fwd3;
      eye4  <= eye3;

      for (int i = 0; i < 3; i++) du5[i] <= nu4[i] * eye4[i];
      e3_s5 <= lav_pkg::col3(dot_s4);
      e3_f5 <= lav_pkg::col3(dot_f4);
      nu5   <= nu4;
      side5 <= side4;
      fwd5  <= fwd4;

      dot_u6 <= lav_pkg::DOT_W'(du5[0]) + lav_pkg::DOT_W'(du5[1]) + lav_pkg::DOT_W'(du5[2]);
      e3_s6  <= e3_s5;
      e3_f6  <= e3_f5;
      nu6    <= nu5;
      side6  <= side5;
      fwd6   <= fwd5;

      mat7.r0.e0 <= lav_pkg::q16_t'(side6[0]);
      mat7.r0.e1 <= lav_pkg::q16_t'(side6[1]);
      mat7.r0.e2 <= lav_pkg::q16_t'(side6[2]);
      mat7.r0.e3 <= e3_s6;
      mat7.r1.e0 <= lav_pkg::q16_t'(nu6[0]);
      mat7.r1.e1 <= lav_pkg::q16_t'(nu6[1]);
      mat7.r1.e2 <= lav_pkg::q16_t'(nu6[2]);
      mat7.r1.e3 <= lav_pkg::col3(dot_u6);
      mat7.r2.e0 <= -lav_pkg::q16_t'(fwd6[0]);
      mat7.r2.e1 <= -lav_pkg::q16_t'(fwd6[1]);
      mat7.r2.e2 <= -lav_pkg::q16_t'(fwd6[2]);
      mat7.r2.e3 <= e3_f6;
    end
  end

  lav_rows u_rows (
    .clk        (clk),
    .rst        (rst),
    .item_valid (v7),
    .item_ready (ser_ready),
    .mat        (mat7),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .entry_0    (entry_0),
    .entry_1    (entry_1),
    .entry_2    (entry_2),
    .entry_3    (entry_3),
    .last_row   (last_row)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
    logic        last;
  } view_row_t;

  typedef logic signed [63:0] s64_t;

  // camera math predictor, fixed point, 64-bit working precision
  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magn(input s64_t x);
    return x < 0 ? -x : x;
  endfunction

  task automatic unit_vec(input s64_t v[3], output s64_t u[3]);
    logic [63:0] a[3];
    logic [63:0] mx;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] q;
    int len;
    mx = 0;
    s = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magn(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (len < 64 && (mx >> len) != 0) len++;
    for (int i = 0; i < 3; i++) begin
      if (len > lav_pkg::NORM_TOP) a[i] = a[i] >> (len - lav_pkg::NORM_TOP);
      else a[i] = a[i] << (lav_pkg::NORM_TOP - len);
      s = s + a[i] * a[i];
    end
    m = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * lav_pkg::Q_ONE + (m >> 1)) / m;
      u[i] = v[i] < 0 ? -s64_t'(q) : s64_t'(q);
    end
  endtask

  function automatic s64_t rnd16(input s64_t x);
    logic [63:0] r;
    r = (magn(x) + lav_pkg::HALF) >> lav_pkg::FRAC;
    return x < 0 ? -s64_t'(r) : s64_t'(r);
  endfunction

  function automatic logic [31:0] clamp32(input s64_t x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  task automatic view_rows(input logic [31:0] p[9], output view_row_t rows[4]);
    s64_t eye[3], fr[3], ur[3], sr[3], f[3], u[3], sd[3], nu[3];
    s64_t m[3][3];
    s64_t dot;
    for (int i = 0; i < 3; i++) begin
      eye[i] = s64_t'($signed(p[i]));
      fr[i] = s64_t'($signed(p[3+i])) - eye[i];
      ur[i] = s64_t'($signed(p[6+i]));
    end
    unit_vec(fr, f);
    unit_vec(ur, u);
    sr[0] = f[1]*u[2] - f[2]*u[1];
    sr[1] = f[2]*u[0] - f[0]*u[2];
    sr[2] = f[0]*u[1] - f[1]*u[0];
    unit_vec(sr, sd);
    nu[0] = rnd16(sd[1]*f[2] - sd[2]*f[1]);
    nu[1] = rnd16(sd[2]*f[0] - sd[0]*f[2]);
    nu[2] = rnd16(sd[0]*f[1] - sd[1]*f[0]);
    for (int i = 0; i < 3; i++) begin
      m[0][i] = sd[i];
      m[1][i] = nu[i];
      m[2][i] = -f[i];
    end
    for (int r = 0; r < 3; r++) begin
      dot = m[r][0]*eye[0] + m[r][1]*eye[1] + m[r][2]*eye[2];
      rows[r].idx = r[1:0];
      rows[r].e0 = clamp32(m[r][0]);
      rows[r].e1 = clamp32(m[r][1]);
      rows[r].e2 = clamp32(m[r][2]);
      rows[r].e3 = clamp32(-rnd16(dot));
      rows[r].last = 1'b0;
    end
    rows[3].idx = lav_pkg::ROW_LAST;
    rows[3].e0 = 0;
    rows[3].e1 = 0;
    rows[3].e2 = 0;
    rows[3].e3 = lav_pkg::Q_ONE;
    rows[3].last = 1'b1;
  endtask

  class view_scoreboard;
    view_row_t pending_rows[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task note_request(input logic [31:0] p[9]);
      view_row_t rows[4];
      view_rows(p, rows);
      for (int i = 0; i < 4; i++) pending_rows.push_back(rows[i]);
    endtask

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_row(input view_row_t got);
      view_row_t w;
      if (pending_rows.size() == 0) begin
        report("unexpected row", got.e0, 0);
        return;
      end
      w = pending_rows.pop_front();
      if (got.idx !== w.idx) report("row_index", got.idx, w.idx);
      if (got.e0 !== w.e0) report("entry_0", got.e0, w.e0);
      if (got.e1 !== w.e1) report("entry_1", got.e1, w.e1);
      if (got.e2 !== w.e2) report("entry_2", got.e2, w.e2);
      if (got.e3 !== w.e3) report("entry_3", got.e3, w.e3);
      if (got.last !== w.last) report("last_row", got.last, w.last);
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] eye_x, eye_y, eye_z;
  logic signed [31:0] target_x, target_y, target_z;
  logic signed [31:0] upward_x, upward_y, upward_z;
  logic out_valid;
  logic out_ready;
  logic [1:0] row_index;
  logic signed [31:0] entry_0, entry_1, entry_2, entry_3;
  logic last_row;

  view_scoreboard sb;
  int cycles;
  bit hold_sink;
  bit random_phase;

  look_at_view_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index), .entry_0(entry_0), .entry_1(entry_1),
    .entry_2(entry_2), .entry_3(entry_3), .last_row(last_row)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'(lav_pkg::Q_ONE) : -32'(lav_pkg::Q_ONE);
      3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back to back requests
  task automatic send_request(input logic [31:0] p[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    eye_x <= p[0]; eye_y <= p[1]; eye_z <= p[2];
    target_x <= p[3]; target_y <= p[4]; target_z <= p[5];
    upward_x <= p[6]; upward_y <= p[7]; upward_z <= p[8];
    do @(posedge clk); while (!in_ready);
    sb.note_request(p);
  endtask

  task automatic send_vec(input logic [31:0] e[3], input logic [31:0] t[3],
                          input logic [31:0] u[3]);
    logic [31:0] p[9];
    for (int i = 0; i < 3; i++) begin
      p[i] = e[i];
      p[3+i] = t[i];
      p[6+i] = u[i];
    end
    send_request(p);
  endtask

  // sink side
  initial begin
    int g;
    view_row_t got;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.idx = row_index;
        got.e0 = entry_0;
        got.e1 = entry_1;
        got.e2 = entry_2;
        got.e3 = entry_3;
        got.last = last_row;
        sb.check_row(got);
      end
      if (hold_sink) begin
        out_ready <= 1'b0;
      end else if (g > 0) begin
        g--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // long receiver hold-off counted in its own process
  initial begin
    hold_sink = 1'b0;
    wait (random_phase);
    repeat (100) @(posedge clk);
    hold_sink = 1'b1;
    repeat (2000) @(posedge clk);
    hold_sink = 1'b0;
  end

  initial begin
    logic [31:0] e[3], t[3], u[3];
    logic [31:0] p[9];
    sb = new();
    random_phase = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    eye_x <= 0; eye_y <= 0; eye_z <= 0;
    target_x <= 0; target_y <= 0; target_z <= 0;
    upward_x <= 0; upward_y <= 0; upward_z <= 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // standard camera
    e = '{0, 0, 32'(5*lav_pkg::Q_ONE)}; t = '{0, 0, 0}; u = '{0, 32'(lav_pkg::Q_ONE), 0};
    send_vec(e, t, u);
    // eye equal to target
    e = '{32'(3*lav_pkg::Q_ONE), 32'h1234, 32'hffff_0000}; t = e;
    send_vec(e, t, u);
    // up parallel to forward
    e = '{0, 0, 0}; t = '{0, 32'(7*lav_pkg::Q_ONE), 0}; u = '{0, 32'(2*lav_pkg::Q_ONE), 0};
    send_vec(e, t, u);
    // zero up hint
    t = '{32'(lav_pkg::Q_ONE), 32'(lav_pkg::Q_ONE), 32'(lav_pkg::Q_ONE)}; u = '{0, 0, 0};
    send_vec(e, t, u);
    // extremes, forward spans 33 bits, column 3 saturates
    e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    t = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    u = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001};
    send_vec(e, t, u);
    e = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    t = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    u = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_vec(e, t, u);
    e = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    t = '{32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff};
    u = '{32'hffff_ffff, 32'h1, 32'h0};
    send_vec(e, t, u);
    e = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    t = '{0, 0, 0}; u = '{32'h1, 32'h0, 32'h0};
    send_vec(e, t, u);
    e = '{32'h7fff_0000, 32'h8001_0000, 32'h7fff_0000};
    t = '{0, 0, 32'h7fff_0000}; u = '{0, 32'(lav_pkg::Q_ONE), 0};
    send_vec(e, t, u);
    in_valid <= 1'b0;

    // pause until all rows are back
    while (sb.pending_rows.size() != 0) @(posedge clk);

    random_phase = 1;
    for (int n = 0; n < 180; n++) begin
      for (int i = 0; i < 9; i++) p[i] = rand_q();
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) p[3+i] = p[i];
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) p[6+i] = p[3+i] - p[i];
      send_request(p);
    end
    in_valid <= 1'b0;

    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
